### rtl/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types, register map and codes of the button debounce and press
// classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  // Switch count and raw pin field width
  localparam int NUM_SWITCHES_DEF = 3;
  localparam int PIN_W            = 3;
  localparam int CNT_W            = 8;
  localparam int PAT_W            = 8;

  // Register map (byte addresses 4*i)
  localparam int          ADDR_W       = 4;
  localparam logic [1:0]  REG_DEBOUNCE = 2'd0;
  localparam logic [1:0]  REG_SETTLE   = 2'd1;
  localparam logic [1:0]  REG_REPEAT   = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd5;
  localparam logic [CNT_W-1:0] SETTLE_RST   = 8'd10;
  localparam logic [CNT_W-1:0] REPEAT_RST   = 8'd20;

  // Event kinds
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_CHANGE  = 2'd1;
  localparam logic [1:0] EV_REPEAT  = 2'd2;
  localparam logic [1:0] EV_RELEASE = 2'd3;

  // Action codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ONOFF = 2'd1;
  localparam logic [1:0] ACT_PLUS  = 2'd2;
  localparam logic [1:0] ACT_MINUS = 2'd3;

  // Patterns of interest (active low)
  localparam logic [PAT_W-1:0] PAT_ALL_UP  = 8'hff;
  localparam logic [PAT_W-1:0] PAT_SW0     = 8'hfe;
  localparam logic [PAT_W-1:0] PAT_SW1     = 8'hfd;
  localparam logic [PAT_W-1:0] PAT_SW2     = 8'hfb;
  localparam logic [CNT_W-1:0] HOLD_MAX    = 8'd255;

  typedef struct packed {
    logic [1:0]       event_kind;
    logic [PAT_W-1:0] event_pattern;
    logic [CNT_W-1:0] hold_time;
    logic [PAT_W-1:0] new_press_mask;
    logic [1:0]       action;
    logic             still_held;
  } result_t;

endpackage

### rtl/bdpc_debounce.sv
// ----------------------------------------------------------------------------
// bdpc_debounce
// Run-length debouncer for one switch; gives the debounced state that
// follows the current sample.
// ----------------------------------------------------------------------------
module bdpc_debounce (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       raw_pressed,
  input  logic [bdpc_pkg::CNT_W-1:0] debounce_limit,
  output logic                       pressed_next
);
  import bdpc_pkg::*;

  logic [CNT_W-1:0] press_run;
  logic [CNT_W-1:0] release_run;
  logic             pressed;
  logic [CNT_W-1:0] press_run_next;
  logic [CNT_W-1:0] release_run_next;

  // Count the current run; flip state once it passes the limit
  always_comb begin
    press_run_next   = press_run;
    release_run_next = release_run;
    pressed_next     = pressed;
    if (raw_pressed) begin
      release_run_next = '0;
      if (press_run >= debounce_limit) begin
        pressed_next = 1'b1;
      end else begin
        press_run_next = press_run + CNT_W'(1);
      end
    end else begin
      press_run_next = '0;
      if (release_run >= debounce_limit) begin
        pressed_next = 1'b0;
      end else begin
        release_run_next = release_run + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_run   <= '0;
      release_run <= '0;
      pressed     <= 1'b0;
    end else if (en) begin
      press_run   <= press_run_next;
      release_run <= release_run_next;
      pressed     <= pressed_next;
    end
  end

endmodule

### rtl/bdpc_classify.sv
// ----------------------------------------------------------------------------
// bdpc_classify
// Pattern tracker: settle, hold repeat and release events, plus action
// mapping for a single pressed switch.
// ----------------------------------------------------------------------------
module bdpc_classify (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [bdpc_pkg::PAT_W-1:0] pattern,
  input  logic [bdpc_pkg::CNT_W-1:0] settle_ticks,
  input  logic [bdpc_pkg::CNT_W-1:0] repeat_ticks,
  output bdpc_pkg::result_t          res
);
  import bdpc_pkg::*;

  logic [PAT_W-1:0] previous_pattern, previous_pattern_next;
  logic [CNT_W-1:0] stable_count, stable_count_next;
  logic [CNT_W-1:0] hold_count, hold_count_next;
  logic [PAT_W-1:0] settled_pattern, settled_pattern_next;
  logic [PAT_W-1:0] pressed_delta, pressed_delta_next;
  logic [PAT_W-1:0] last_event_mask, last_event_mask_next;
  logic [CNT_W-1:0] stable_inc;
  logic [CNT_W-1:0] hold_inc;

  assign stable_inc = stable_count + CNT_W'(1);
  assign hold_inc   = hold_count + CNT_W'(1);

  // Advance the pattern state and build the event of this tick
  always_comb begin
    previous_pattern_next = previous_pattern;
    stable_count_next     = stable_count;
    hold_count_next       = hold_count;
    settled_pattern_next  = settled_pattern;
    pressed_delta_next    = pressed_delta;
    last_event_mask_next  = last_event_mask;
    res                   = '0;

    if (pattern == previous_pattern) begin
      stable_count_next = stable_inc;
      if (settled_pattern != pattern) begin
        if (stable_inc == settle_ticks) begin
          stable_count_next    = '0;
          hold_count_next      = '0;
          settled_pattern_next = pattern;
          // newly pressed: released in the old pattern, pressed in the new one
          pressed_delta_next   = (pattern ^ settled_pattern) & settled_pattern;
          last_event_mask_next = pressed_delta_next;
          res.event_kind       = EV_CHANGE;
          res.event_pattern    = pattern;
        end
      end else if (stable_inc == repeat_ticks) begin
        stable_count_next = '0;
        if (hold_count != HOLD_MAX) begin
          hold_count_next      = hold_inc;
          last_event_mask_next = pressed_delta;
          res.event_kind       = EV_REPEAT;
          res.event_pattern    = settled_pattern;
          res.hold_time        = hold_inc;
        end
      end
    end else begin
      if (pattern == PAT_ALL_UP) begin
        if (settled_pattern != '0) begin
          last_event_mask_next = pressed_delta;
          res.event_kind       = EV_RELEASE;
          res.event_pattern    = settled_pattern;
          res.hold_time        = hold_count;
        end
        settled_pattern_next = '0;
        pressed_delta_next   = '0;
      end
      stable_count_next     = '0;
      hold_count_next       = '0;
      previous_pattern_next = pattern;
    end

    res.new_press_mask = last_event_mask_next;
    res.still_held     = (res.event_kind == EV_CHANGE) || (res.event_kind == EV_REPEAT);
    res.action         = ACT_NONE;
    if ((res.event_kind != EV_NONE) && (last_event_mask_next != '0)) begin
      priority if (res.event_pattern == PAT_SW0) begin
        res.action = ACT_ONOFF;
      end else if (res.event_pattern == PAT_SW1) begin
        res.action = ACT_PLUS;
      end else if (res.event_pattern == PAT_SW2) begin
        res.action = ACT_MINUS;
      end else begin
        res.action = ACT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pattern <= '0;
      stable_count     <= '0;
      hold_count       <= '0;
      settled_pattern  <= '0;
      pressed_delta    <= '0;
      last_event_mask  <= '0;
    end else if (en) begin
      previous_pattern <= previous_pattern_next;
      stable_count     <= stable_count_next;
      hold_count       <= hold_count_next;
      settled_pattern  <= settled_pattern_next;
      pressed_delta    <= pressed_delta_next;
      last_event_mask  <= last_event_mask_next;
    end
  end

endmodule

### rtl/button_debounce_press_classifier_core.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_core
// Debounces raw active-low switch pins per sampling tick and classifies the
// settled pattern into change, hold repeat and release events.
// ----------------------------------------------------------------------------
// Each input transaction is one sampling tick and yields exactly one output
// transaction (event_kind none when nothing happened). A tick passes through
// the per-switch debouncers and the pattern classifier in the cycle it is
// accepted, and its result is held in the output register.
// A new tick is accepted every cycle while the output register is empty or
// being drained, so the sustained rate is one tick per clock. Write the
// registers only while no tick is in flight.
module button_debounce_press_classifier_core #(
  parameter int NUM_SWITCHES = bdpc_pkg::NUM_SWITCHES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // tick input
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [2:0] pin_levels
  // event output
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,   // [7:0] event_pattern, [15:8] hold_time,
                                                 // [23:16] new_press_mask, [25:24] action,
                                                 // [26] still_held
  output logic [1:0]                  m_tuser,   // [1:0] event_kind
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bdpc_pkg::*;

  logic [CNT_W-1:0]        debounce_limit;
  logic [CNT_W-1:0]        settle_ticks;
  logic [CNT_W-1:0]        repeat_ticks;
  logic                    cfg_wr;
  logic [1:0]              reg_sel;
  logic                    accept;
  logic [PIN_W-1:0]        pin_levels;
  logic [NUM_SWITCHES-1:0] pressed_vec;
  logic [PAT_W-1:0]        pattern;
  result_t                 res;
  result_t                 out_res;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit <= DEBOUNCE_RST;
      settle_ticks   <= SETTLE_RST;
      repeat_ticks   <= REPEAT_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DEBOUNCE: debounce_limit <= pwdata[CNT_W-1:0];
        REG_SETTLE:   settle_ticks   <= pwdata[CNT_W-1:0];
        REG_REPEAT:   repeat_ticks   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_DEBOUNCE: prdata[CNT_W-1:0] = debounce_limit;
      REG_SETTLE:   prdata[CNT_W-1:0] = settle_ticks;
      REG_REPEAT:   prdata[CNT_W-1:0] = repeat_ticks;
      default:      prdata = '0;
    endcase
  end

  // Accept a tick whenever the output register is free or draining
  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign pin_levels = s_tdata[PIN_W-1:0];

  // One debouncer per switch; switches past the pin field read pressed
  for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_sw
    logic raw_pressed;
    if (i < PIN_W) begin : g_pin
      assign raw_pressed = !pin_levels[i];
    end else begin : g_tied
      assign raw_pressed = 1'b1;
    end
    bdpc_debounce u_debounce (
      .clk            (clk),
      .rst            (rst),
      .en             (accept),
      .raw_pressed    (raw_pressed),
      .debounce_limit (debounce_limit),
      .pressed_next   (pressed_vec[i])
    );
  end

  // Build the active-low pattern; unused bits read released
  always_comb begin
    pattern = PAT_ALL_UP;
    for (int k = 0; k < NUM_SWITCHES; k++) begin
      pattern[k] = !pressed_vec[k];
    end
  end

  bdpc_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .en           (accept),
    .pattern      (pattern),
    .settle_ticks (settle_ticks),
    .repeat_ticks (repeat_ticks),
    .res          (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.event_kind;
  assign m_tdata = {5'd0, out_res.still_held, out_res.action, out_res.new_press_mask,
                    out_res.hold_time, out_res.event_pattern};

`ifndef SYNTHESIS
  // An accepted tick always leaves a result waiting
  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted tick produced no result");

  // A stalled result is not overwritten
  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // still_held only for change and repeat events
  a_still_held : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[26]) |-> (m_tuser == EV_CHANGE || m_tuser == EV_REPEAT))
    else $error("still_held on wrong event kind");

  // No event carries no pattern and no action
  a_none_empty : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == EV_NONE) |-> (m_tdata[7:0] == '0 && m_tdata[25:24] == ACT_NONE))
    else $error("empty event carries payload");
`endif

endmodule
